### sv/ssh_pkg.sv
// ----------------------------------------------------------------------------
// ssh_pkg
// Shared types and codes of the sponge hash engine: action codes, item
// field widths, sequencer states and the permutation memory request.
// ----------------------------------------------------------------------------
package ssh_pkg;

	localparam int ACT_W    = 2;
	localparam int BYTE_W   = 8;
	localparam int ENTRY_W  = 8;	// widest table index or entry value

	localparam logic [ACT_W-1:0] ACT_INIT    = 2'd0;
	localparam logic [ACT_W-1:0] ACT_ABSORB  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_SQUEEZE = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_U0,
		ST_U1,
		ST_U2,
		ST_U3,
		ST_U4,
		ST_A0,
		ST_A1,
		ST_A2,
		ST_A3,
		ST_O0,
		ST_O1,
		ST_O2,
		ST_O3,
		ST_EMIT
	} st_t;

	typedef struct packed {
		logic               clr;
		logic               re;
		logic [ENTRY_W-1:0] raddr;
		logic               we;
		logic [ENTRY_W-1:0] waddr;
		logic [ENTRY_W-1:0] wdata;
	} mem_req_t;

endpackage

### sv/ssh_if.sv
// ----------------------------------------------------------------------------
// ssh_if
// Valid/ready channels of the sponge hash engine: the command channel
// (action, data_byte) and the digest channel (digest_byte).
// ----------------------------------------------------------------------------
interface ssh_cmd_if;
	logic                         valid;
	logic                         ready;
	logic [ssh_pkg::ACT_W-1:0]    action;
	logic [ssh_pkg::BYTE_W-1:0]   data_byte;

	modport source (output valid, output action, output data_byte, input ready);
	modport sink   (input valid, input action, input data_byte, output ready);
endinterface

interface ssh_dig_if;
	logic                         valid;
	logic                         ready;
	logic [ssh_pkg::BYTE_W-1:0]   digest_byte;

	modport source (output valid, output digest_byte, input ready);
	modport sink   (input valid, input digest_byte, output ready);
endinterface

### sv/ssh_perm_mem.sv
// ----------------------------------------------------------------------------
// ssh_perm_mem
// Permutation table: one write and one read port, read data registered.
// Per-entry valid bits make an unwritten entry read as its own index.
// ----------------------------------------------------------------------------
module ssh_perm_mem #(
	parameter int PERM_SIZE = 256,
	parameter int IW        = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ssh_pkg::mem_req_t req,
	output logic [IW-1:0]     rdata
);
	import ssh_pkg::*;

	logic [IW-1:0] mem_q [PERM_SIZE];
	logic [PERM_SIZE-1:0] vld_q;
	logic [IW-1:0] rd_data_q;
	logic [IW-1:0] rd_addr_q;
	logic          rd_vld_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr[IW-1:0]] <= req.wdata[IW-1:0];
		end
		if (req.re) begin
			rd_data_q <= mem_q[req.raddr[IW-1:0]];
			rd_addr_q <= req.raddr[IW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (req.clr) begin
				vld_q <= '0;
			end else if (req.we) begin
				vld_q[req.waddr[IW-1:0]] <= 1'b1;
			end
			if (req.re) begin
				rd_vld_q <= vld_q[req.raddr[IW-1:0]];
			end
		end
	end

	// unwritten entries hold the identity permutation
	assign rdata = rd_vld_q ? rd_data_q : rd_addr_q;

endmodule

### sv/spritz_sponge_hash_engine.sv
// ----------------------------------------------------------------------------
// spritz_sponge_hash_engine
// Sponge hash over a byte permutation, simplified Spritz form, with a
// sequencer that drives one permutation memory.
// ----------------------------------------------------------------------------
// The engine takes one command item at a time (init, absorb a byte, squeeze
// a byte) and answers each squeeze with one digest item. All table traffic
// goes through a single memory that does one read and one write per cycle
// with registered read data, so the memory port sets the rate: an update
// runs the steps U0 to U4, a nibble swap a check step and A0 to A3, an output
// step O0 to O3 and then the hand-off to the output register. Init clears
// the table at once through per-entry valid bits.
// An absorb runs two nibble swaps; once every PERM_SIZE/4 bytes it also runs
// a whip of WHIP_ROUNDS updates.
// A squeeze runs one update and one output step, after a whip of WHIP_ROUNDS
// updates when bytes were absorbed since the last whip. The next command is
// taken once the engine is idle, even while a digest item still waits in the
// output register.
// ----------------------------------------------------------------------------
module spritz_sponge_hash_engine #(
	parameter int WHIP_ROUNDS = 512,
	parameter int PERM_SIZE   = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	ssh_cmd_if.sink   cmd,
	ssh_dig_if.source dig
);
	import ssh_pkg::*;

	localparam int IW   = $clog2(PERM_SIZE);
	localparam int SW   = IW + 2;
	localparam int CW   = $clog2(WHIP_ROUNDS + 1);
	localparam int HALF = PERM_SIZE / 2;

	localparam logic [SW-1:0] PW   = SW'(PERM_SIZE);
	localparam logic [SW-1:0] HW   = SW'(HALF);
	localparam logic [CW-1:0] LAST = CW'(WHIP_ROUNDS - 1);

	// fold a sum below twice the table size back into range
	function automatic logic [SW-1:0] fold(input logic [SW-1:0] s);
		fold = (s >= PW) ? s - PW : s;
	endfunction

	function automatic logic [IW-1:0] add_mod(input logic [IW-1:0] a, input logic [IW-1:0] b);
		logic [SW-1:0] s;
		s = fold({2'b00, a} + {2'b00, b});
		add_mod = s[IW-1:0];
	endfunction

	st_t state_q, state_d;

	// engine registers
	logic [IW-1:0] pos_q, i_q, j_q, k_q, last_q, w_q;
	logic          whip_q, nib_q;
	logic [CW-1:0] cnt_q;
	logic [ACT_W-1:0]  act_q;
	logic [BYTE_W-1:0] byte_q;
	logic [IW-1:0]     tmp_q;

	logic              dig_vld_q;
	logic [BYTE_W-1:0] dig_data_q;

	mem_req_t      req;
	logic [IW-1:0] rdata;

	// datapath terms
	logic [3:0]    nibble;
	logic [IW-1:0] q_addr, i_nx, y_addr, j_nx, k_nx, y1_addr, x1_addr, y2_addr, w_nx;
	logic          whip_start, whip_end, acc, dig_load;

	ssh_perm_mem #(
		.PERM_SIZE (PERM_SIZE),
		.IW        (IW)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rdata  (rdata)
	);

	assign nibble = nib_q ? byte_q[7:4] : byte_q[3:0];

	always_comb begin
		logic [SW-1:0] s;
		s       = fold(HW + SW'(nibble));
		q_addr  = s[IW-1:0];
		i_nx    = add_mod(i_q, w_q);
		y_addr  = add_mod(j_q, rdata);
		j_nx    = add_mod(k_q, rdata);
		k_nx    = add_mod(add_mod(i_q, k_q), rdata);
		y1_addr = add_mod(last_q, k_q);
		x1_addr = add_mod(i_q, rdata);
		y2_addr = add_mod(j_q, rdata);
		s       = fold({2'b00, w_q} + SW'(2));
		w_nx    = s[IW-1:0];
	end

	assign whip_start = (act_q == ACT_ABSORB) ? ({2'b00, pos_q} >= HW) : (pos_q != '0);
	assign whip_end   = whip_q && (cnt_q == LAST);
	assign acc        = cmd.valid && cmd.ready;
	assign dig_load   = (state_q == ST_EMIT) && (!dig_vld_q || dig.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer: next state and memory requests
	always_comb begin
		state_d   = state_q;
		req       = '0;
		cmd.ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd.ready = 1'b1;
				if (cmd.valid) begin
					case (cmd.action)
						ACT_INIT:    req.clr = 1'b1;
						ACT_ABSORB:  state_d = ST_CHECK;
						ACT_SQUEEZE: state_d = ST_CHECK;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_CHECK: begin
				if (act_q == ACT_ABSORB && !whip_start) begin
					state_d = ST_A0;
				end else begin
					state_d = ST_U0;
				end
			end
			ST_U0: begin
				req.re    = 1'b1;
				req.raddr = ENTRY_W'(i_nx);
				state_d   = ST_U1;
			end
			ST_U1: begin
				req.re    = 1'b1;
				req.raddr = ENTRY_W'(y_addr);
				state_d   = ST_U2;
			end
			ST_U2: begin
				req.re    = 1'b1;
				req.raddr = ENTRY_W'(j_nx);
				state_d   = ST_U3;
			end
			ST_U3: begin
				req.we    = 1'b1;
				req.waddr = ENTRY_W'(i_q);
				req.wdata = ENTRY_W'(rdata);
				state_d   = ST_U4;
			end
			ST_U4: begin
				req.we    = 1'b1;
				req.waddr = ENTRY_W'(j_q);
				req.wdata = ENTRY_W'(tmp_q);
				if (!whip_q) begin
					state_d = ST_O0;
				end else if (whip_end && act_q == ACT_ABSORB) begin
					state_d = ST_A0;
				end else begin
					state_d = ST_U0;
				end
			end
			ST_A0: begin
				req.re    = 1'b1;
				req.raddr = ENTRY_W'(pos_q);
				state_d   = ST_A1;
			end
			ST_A1: begin
				req.re    = 1'b1;
				req.raddr = ENTRY_W'(q_addr);
				state_d   = ST_A2;
			end
			ST_A2: begin
				req.we    = 1'b1;
				req.waddr = ENTRY_W'(pos_q);
				req.wdata = ENTRY_W'(rdata);
				state_d   = ST_A3;
			end
			ST_A3: begin
				req.we    = 1'b1;
				req.waddr = ENTRY_W'(q_addr);
				req.wdata = ENTRY_W'(tmp_q);
				state_d   = nib_q ? ST_IDLE : ST_CHECK;
			end
			ST_O0: begin
				req.re    = 1'b1;
				req.raddr = ENTRY_W'(y1_addr);
				state_d   = ST_O1;
			end
			ST_O1: begin
				req.re    = 1'b1;
				req.raddr = ENTRY_W'(x1_addr);
				state_d   = ST_O2;
			end
			ST_O2: begin
				req.re    = 1'b1;
				req.raddr = ENTRY_W'(y2_addr);
				state_d   = ST_O3;
			end
			ST_O3: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				// hold the result until the output register is free
				if (!dig_vld_q || dig.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// engine registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			i_q    <= '0;
			j_q    <= '0;
			k_q    <= '0;
			last_q <= '0;
			w_q    <= IW'(1);
			whip_q <= 1'b0;
			nib_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					nib_q <= 1'b0;
					if (acc && cmd.action == ACT_INIT) begin
						pos_q  <= '0;
						i_q    <= '0;
						j_q    <= '0;
						k_q    <= '0;
						last_q <= '0;
						w_q    <= IW'(1);
					end
				end
				ST_CHECK: begin
					if (whip_start) begin
						whip_q <= 1'b1;
						cnt_q  <= '0;
					end
				end
				ST_U0: i_q <= i_nx;
				ST_U2: j_q <= j_nx;
				ST_U3: k_q <= k_nx;
				ST_U4: begin
					// close the whip after its last round
					if (whip_end) begin
						whip_q <= 1'b0;
						w_q    <= w_nx;
						pos_q  <= '0;
					end else if (whip_q) begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_A3: begin
					pos_q <= pos_q + IW'(1);
					nib_q <= ~nib_q;
				end
				ST_O3: last_q <= rdata;
				default: begin
				end
			endcase
		end
	end

	// command latch and swap temporary
	always_ff @(posedge clk) begin
		if (acc) begin
			act_q  <= cmd.action;
			byte_q <= cmd.data_byte;
		end
		if (state_q == ST_U1 || state_q == ST_A1) begin
			tmp_q <= rdata;
		end
	end

	// digest output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dig_vld_q <= 1'b0;
		end else if (dig_load) begin
			dig_vld_q <= 1'b1;
		end else if (dig.ready) begin
			dig_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dig_load) begin
			dig_data_q <= BYTE_W'(last_q);
		end
	end

	assign dig.valid       = dig_vld_q;
	assign dig.digest_byte = dig_data_q;

endmodule
